### sv/bpm_dos_pkg.sv
// Shared widths, register indexes and the sideband record for the
// delta-over-sigma position block. No dependencies.
`default_nettype none
package bpm_dos_pkg;
   localparam int AMP_WIDTH_DEF = 32;
   localparam int AMP_PORT_W    = 32;
   localparam int GAIN_W        = 32;
   localparam int SUM_W         = 34;
   localparam int NUM_W         = 65;
   localparam int DEN_W         = 34;
   localparam int QUO_W         = 32;
   localparam int DIV_LAT       = QUO_W + 1;
   localparam int PP_SPLIT      = 17;
   localparam int ADDR_W        = 4;
   localparam int DATA_W        = 32;

   typedef enum logic [1:0] {
      REG_GAIN_X = 2'd0,
      REG_GAIN_Y = 2'd1,
      REG_GAIN_Q = 2'd2,
      REG_NONE   = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic                    zero_out;
      logic                    fault;
      logic                    last;
      logic                    neg_x;
      logic                    neg_y;
      logic                    neg_q;
   } side_type;
endpackage
`default_nettype wire

### sv/bpm_dos_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Flags quotients of 2**QUO_W or more. Uses bpm_dos_pkg.
`default_nettype none
module bpm_dos_div (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [bpm_dos_pkg::NUM_W-1:0]  num,
   input  logic [bpm_dos_pkg::DEN_W-1:0]  den,
   output logic [bpm_dos_pkg::QUO_W-1:0]  quo,
   output logic                           ovf
);
   import bpm_dos_pkg::*;

   logic [DEN_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];

   // entry: overflow check against the upper numerator bits
   always_ff @(posedge clock) begin
      if (enable) begin
         ovf_ff[0] <= {1'b0, num[NUM_W-1:QUO_W]} >= den;
         rem_ff[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
         low_ff[0] <= num[QUO_W-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;
      logic [DEN_W:0] diff;
      always_comb begin
         trial = {rem_ff[k], low_ff[k][QUO_W-1]};
         ge    = trial >= {1'b0, den_ff[k]};
         diff  = trial - {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff[k+1] <= {quo_ff[k][QUO_W-2:0], ge};
            low_ff[k+1] <= {low_ff[k][QUO_W-2:0], 1'b0};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];
endmodule
`default_nettype wire

### sv/bpm_delta_over_sigma_position.sv
// Four-button BPM position by delta over sigma, top level.
// Depends on bpm_dos_pkg and bpm_dos_div.
//
// Usage:
//  - req_ channel: one beat carries amplitudes A..D and frame_last.
//  - rsp_ channel: one beat per input beat, same order: pos_x, pos_y,
//    skew_q (gain * diff / sum, truncated toward zero, saturated to 32 bits),
//    exact 34-bit amp_sum, sum_zero_fault and out_last.
//  - csr_ port: APB-style, gain_x at 0x0, gain_y at 0x4, gain_q at 0x8,
//    all reset to 1. Write gains only while the pipe is empty.
//  - Throughput: one beat per cycle, sustained while rsp_ready is high.
//  - Pipeline: 37 register stages: three front stages (sum/diff, split
//    32x17 products, product add), 33 divider stages (overflow check, then
//    one quotient bit each) and the saturating output register. rsp_valid
//    is registered alongside the result through a valid chain of equal
//    depth. The divider chain is the longest part of the pipe.
//  - Stall: the whole pipe advances on one enable, high when the output
//    register is empty or being taken; req_ready follows it. Nothing is
//    dropped or repeated while stalled.
//  - Reset (synchronous): all valid bits clear, gains return to 1.
//  - Zero sum with some amplitude nonzero: positions are 0, fault set.
`default_nettype none
module bpm_delta_over_sigma_position #(
   parameter int AMP_WIDTH = bpm_dos_pkg::AMP_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bpm_dos_pkg::AMP_PORT_W-1:0]    req_amp_a,
   input  logic [bpm_dos_pkg::AMP_PORT_W-1:0]    req_amp_b,
   input  logic [bpm_dos_pkg::AMP_PORT_W-1:0]    req_amp_c,
   input  logic [bpm_dos_pkg::AMP_PORT_W-1:0]    req_amp_d,
   input  logic                                  req_frame_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bpm_dos_pkg::QUO_W-1:0]  rsp_pos_x,
   output logic signed [bpm_dos_pkg::QUO_W-1:0]  rsp_pos_y,
   output logic signed [bpm_dos_pkg::QUO_W-1:0]  rsp_skew_q,
   output logic signed [bpm_dos_pkg::SUM_W-1:0]  rsp_amp_sum,
   output logic                                  rsp_sum_zero_fault,
   output logic                                  rsp_out_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bpm_dos_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [bpm_dos_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [bpm_dos_pkg::DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import bpm_dos_pkg::*;

   localparam int SIDE_N = DIV_LAT + 3;

   // ---------------- configuration registers ----------------
   logic signed [GAIN_W-1:0] gain_x_ff, gain_y_ff, gain_q_ff;
   reg_idx_type              csr_idx;
   logic                     csr_wr;

   assign csr_idx    = reg_idx_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff <= GAIN_W'(1);
         gain_y_ff <= GAIN_W'(1);
         gain_q_ff <= GAIN_W'(1);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GAIN_X: gain_x_ff <= csr_pwdata;
            REG_GAIN_Y: gain_y_ff <= csr_pwdata;
            REG_GAIN_Q: gain_q_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_GAIN_X: csr_prdata = gain_x_ff;
         REG_GAIN_Y: csr_prdata = gain_y_ff;
         REG_GAIN_Q: csr_prdata = gain_q_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- pipe control ----------------
   logic enable;
   logic rsp_valid_ff;
   logic v_ff [0:SIDE_N-1];

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_N; i++) v_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < SIDE_N; i++) v_ff[i] <= v_ff[i-1];
         rsp_valid_ff <= v_ff[SIDE_N-1];
      end
   end

   // ---------------- stage 1: sum, differences, signs ----------------
   logic signed [SUM_W-1:0] a_ext, b_ext, c_ext, d_ext;
   logic signed [SUM_W-1:0] sum_in, dx_in, dy_in, dq_in;
   logic                    all_zero;
   side_type                side_in;

   always_comb begin
      a_ext    = SUM_W'($signed(req_amp_a[AMP_WIDTH-1:0]));
      b_ext    = SUM_W'($signed(req_amp_b[AMP_WIDTH-1:0]));
      c_ext    = SUM_W'($signed(req_amp_c[AMP_WIDTH-1:0]));
      d_ext    = SUM_W'($signed(req_amp_d[AMP_WIDTH-1:0]));
      sum_in   = a_ext + b_ext + c_ext + d_ext;
      dx_in    = b_ext + c_ext - a_ext - d_ext;
      dy_in    = a_ext + b_ext - c_ext - d_ext;
      dq_in    = a_ext + c_ext - b_ext - d_ext;
      all_zero = (a_ext == '0) && (b_ext == '0) && (c_ext == '0) && (d_ext == '0);
      side_in.sum      = sum_in;
      side_in.zero_out = (sum_in == '0);
      side_in.fault    = (sum_in == '0) && !all_zero;
      side_in.last     = req_frame_last;
      side_in.neg_x    = (gain_x_ff[GAIN_W-1] ^ dx_in[SUM_W-1]) ^ sum_in[SUM_W-1];
      side_in.neg_y    = (gain_y_ff[GAIN_W-1] ^ dy_in[SUM_W-1]) ^ sum_in[SUM_W-1];
      side_in.neg_q    = (gain_q_ff[GAIN_W-1] ^ dq_in[SUM_W-1]) ^ sum_in[SUM_W-1];
   end

   side_type                side_ff [0:SIDE_N-1];
   logic signed [SUM_W-1:0] dx_ff, dy_ff, dq_ff;
   logic [DEN_W-1:0]        den1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < SIDE_N; i++) side_ff[i] <= side_ff[i-1];
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dq_ff   <= dq_in;
         den1_ff <= sum_in[SUM_W-1] ? DEN_W'(-sum_in) : DEN_W'(sum_in);
      end
   end

   // ---------------- stage 2: split products of magnitudes ----------------
   localparam int PP_W = GAIN_W + PP_SPLIT;
   logic [GAIN_W-1:0] mg_x, mg_y, mg_q;
   logic [SUM_W-1:0]  md_x, md_y, md_q;
   logic [PP_W-1:0]   ppl_x_ff, pph_x_ff, ppl_y_ff, pph_y_ff, ppl_q_ff, pph_q_ff;
   logic [DEN_W-1:0]  den2_ff, den3_ff;

   always_comb begin
      mg_x = gain_x_ff[GAIN_W-1] ? GAIN_W'(-gain_x_ff) : GAIN_W'(gain_x_ff);
      mg_y = gain_y_ff[GAIN_W-1] ? GAIN_W'(-gain_y_ff) : GAIN_W'(gain_y_ff);
      mg_q = gain_q_ff[GAIN_W-1] ? GAIN_W'(-gain_q_ff) : GAIN_W'(gain_q_ff);
      md_x = dx_ff[SUM_W-1] ? SUM_W'(-dx_ff) : SUM_W'(dx_ff);
      md_y = dy_ff[SUM_W-1] ? SUM_W'(-dy_ff) : SUM_W'(dy_ff);
      md_q = dq_ff[SUM_W-1] ? SUM_W'(-dq_ff) : SUM_W'(dq_ff);
   end

   // operands widened to the product width before multiplying
   always_ff @(posedge clock) begin
      if (enable) begin
         ppl_x_ff <= PP_W'(mg_x) * PP_W'(md_x[PP_SPLIT-1:0]);
         pph_x_ff <= PP_W'(mg_x) * PP_W'(md_x[SUM_W-1:PP_SPLIT]);
         ppl_y_ff <= PP_W'(mg_y) * PP_W'(md_y[PP_SPLIT-1:0]);
         pph_y_ff <= PP_W'(mg_y) * PP_W'(md_y[SUM_W-1:PP_SPLIT]);
         ppl_q_ff <= PP_W'(mg_q) * PP_W'(md_q[PP_SPLIT-1:0]);
         pph_q_ff <= PP_W'(mg_q) * PP_W'(md_q[SUM_W-1:PP_SPLIT]);
         den2_ff  <= den1_ff;
      end
   end

   // ---------------- stage 3: full-width numerators ----------------
   logic [NUM_W-1:0] num_x_ff, num_y_ff, num_q_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         num_x_ff <= NUM_W'(ppl_x_ff) + (NUM_W'(pph_x_ff) << PP_SPLIT);
         num_y_ff <= NUM_W'(ppl_y_ff) + (NUM_W'(pph_y_ff) << PP_SPLIT);
         num_q_ff <= NUM_W'(ppl_q_ff) + (NUM_W'(pph_q_ff) << PP_SPLIT);
         den3_ff  <= den2_ff;
      end
   end

   // ---------------- divider chains ----------------
   logic [QUO_W-1:0] quo_x, quo_y, quo_q;
   logic             ovf_x, ovf_y, ovf_q;

   bpm_dos_div u_div_x (.clock(clock), .enable(enable), .num(num_x_ff), .den(den3_ff),
                        .quo(quo_x), .ovf(ovf_x));
   bpm_dos_div u_div_y (.clock(clock), .enable(enable), .num(num_y_ff), .den(den3_ff),
                        .quo(quo_y), .ovf(ovf_y));
   bpm_dos_div u_div_q (.clock(clock), .enable(enable), .num(num_q_ff), .den(den3_ff),
                        .quo(quo_q), .ovf(ovf_q));

   // ---------------- output: sign and saturate ----------------
   localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};
   localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};

   function automatic logic [QUO_W-1:0] sat_pos(input logic [QUO_W-1:0] q,
                                                input logic ovf, input logic neg,
                                                input logic zero);
      logic [QUO_W-1:0] r;
      if (zero)                          r = '0;
      else if (neg && (ovf || q > NEG_LIM))  r = NEG_LIM;
      else if (neg)                      r = QUO_W'(-q);
      else if (ovf || q > POS_LIM)       r = POS_LIM;
      else                               r = q;
      return r;
   endfunction

   side_type tail;
   assign tail = side_ff[SIDE_N-1];

   logic [QUO_W-1:0]        pos_x_ff, pos_y_ff, skew_q_ff;
   logic signed [SUM_W-1:0] amp_sum_ff;
   logic                    fault_ff, last_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         pos_x_ff   <= sat_pos(quo_x, ovf_x, tail.neg_x, tail.zero_out);
         pos_y_ff   <= sat_pos(quo_y, ovf_y, tail.neg_y, tail.zero_out);
         skew_q_ff  <= sat_pos(quo_q, ovf_q, tail.neg_q, tail.zero_out);
         amp_sum_ff <= tail.sum;
         fault_ff   <= tail.fault;
         last_ff    <= tail.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = pos_x_ff;
   assign rsp_pos_y          = pos_y_ff;
   assign rsp_skew_q         = skew_q_ff;
   assign rsp_amp_sum        = amp_sum_ff;
   assign rsp_sum_zero_fault = fault_ff;
   assign rsp_out_last       = last_ff;

`ifndef SYNTHESIS
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum_zero_fault |->
         rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_skew_q == '0 && rsp_amp_sum == '0)
      else $error("fault beat with nonzero positions or sum");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(v_ff[SIDE_N-1]) && $stable(v_ff[0]))
      else $error("pipe moved while stalled");
   a_feed_out: assert property (@(posedge clock) disable iff (reset)
      enable && v_ff[SIDE_N-1] |=> rsp_valid)
      else $error("beat lost at output register");
`endif
endmodule
`default_nettype wire
